FILE: rtl/core/iep_pkg.sv
// Shared types and constants for the ISO 15434 format 09 envelope parser.
// Holds the parse phase encoding, result and error codes, the type-name
// table and the result record. No dependencies.
package iep_pkg;

    // Control characters of the envelope.
    localparam logic [7:0] CHAR_GS    = 8'h1D;
    localparam logic [7:0] CHAR_RS    = 8'h1E;
    localparam logic [7:0] CHAR_EOT   = 8'h04;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_RPAR  = 8'h29;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
    localparam logic [1:0] KIND_RECORD_END = 2'd1;
    localparam logic [1:0] KIND_COMPLETE   = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    // Record types, which are also the rows of the name table.
    localparam logic [1:0] TYPE_BARCODE = 2'd0;

    // Error codes.
    localparam logic [3:0] ERR_NONE   = 4'd0;
    localparam logic [3:0] ERR_LENGTH = 4'd1;
    localparam logic [3:0] ERR_TYPE   = 4'd2;
    localparam logic [3:0] ERR_HEADER = 4'd3;
    localparam logic [3:0] ERR_FORMAT = 4'd4;
    localparam logic [3:0] ERR_NAME   = 4'd5;
    localparam logic [3:0] ERR_NUMBER = 4'd6;
    localparam logic [3:0] ERR_GS     = 4'd7;
    localparam logic [3:0] ERR_RS     = 4'd8;
    localparam logic [3:0] ERR_EOT    = 4'd9;

    localparam int NUM_NAMES = 4;

    // Type names, padded with zero to eight characters: BarCode, BMP, JPEG, TIFF.
    localparam logic [7:0] NAME_CHARS [NUM_NAMES][8] = '{
        '{8'h42, 8'h61, 8'h72, 8'h43, 8'h6F, 8'h64, 8'h65, 8'h00},
        '{8'h42, 8'h4D, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4A, 8'h50, 8'h45, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h54, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{4'd7, 4'd3, 4'd4, 4'd4};

    typedef enum logic [16:0] {
        PH_LEN0   = 17'h00001,
        PH_LEN1   = 17'h00002,
        PH_LEN2   = 17'h00004,
        PH_LEN3   = 17'h00008,
        PH_TYPE   = 17'h00010,
        PH_HDR0   = 17'h00020,
        PH_HDR1   = 17'h00040,
        PH_HDR2   = 17'h00080,
        PH_HDR3   = 17'h00100,
        PH_REC    = 17'h00200,
        PH_FMT9   = 17'h00400,
        PH_GS1    = 17'h00800,
        PH_NAME   = 17'h01000,
        PH_GS2    = 17'h02000,
        PH_DIGITS = 17'h04000,
        PH_DATA   = 17'h08000,
        PH_RSEND  = 17'h10000
    } phase_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  data_type;
        logic [7:0]  data_byte;
        logic [23:0] byte_offset;
        logic [23:0] record_length;
        logic [7:0]  symbology;
        logic [31:0] image_length;
        logic [3:0]  error_code;
    } result_t;

endpackage

FILE: rtl/core/iso15434_envelope_parser.sv
// Top level of the ISO 15434 format 09 envelope parser: input register,
// configuration register and result register around the parse core.
// Depends on iep_pkg and iep_parse.
//
//   Channel   Signals                                   Dir   Beat
//   -------   ---------------------------------------   ---   -------------------------
//   byte      byte_valid, byte_stall, byte_value,       in    one packet byte
//             last_byte
//   result    result_valid, result_stall, result_kind,  out   payload byte, record end,
//             data_type .. error_code                         envelope done or error
//   config    cfg_write_en, cfg_write_data              in    expected message type
//
// Each byte beat passes through the input register and then through the parse
// logic into the result register. A new byte beat is taken every cycle while
// the byte channel is not stalled; the throughput is one byte per cycle, set by
// the single pass of the phase update between the two registers.
// Reset clears the parse state, the message type and both valid flags.
// A stalled result holds the result register and the input register; the
// byte channel stalls only when both are full.
module iso15434_envelope_parser
    import iep_pkg::*;
#(
    parameter int LENGTH_BITS       = 24,
    parameter int MAX_LENGTH_DIGITS = 9
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,

    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  result_kind,
    output logic [1:0]  data_type,
    output logic [7:0]  data_byte,
    output logic [23:0] byte_offset,
    output logic [23:0] record_length,
    output logic [7:0]  symbology,
    output logic [31:0] image_length,
    output logic [3:0]  error_code
);

    logic [7:0] msg_type_reg;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic       out_free;
    logic       step;
    logic       byte_take;
    logic       core_valid;
    result_t    core_res;

    // The result register can load when empty or when its beat leaves now.
    assign out_free   = !out_valid_reg || !result_stall;
    // The byte in the input register is parsed when its result has a place.
    assign step       = in_valid_reg && out_free;
    assign byte_stall = in_valid_reg && !out_free;
    assign byte_take  = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = step && core_valid;
    end

    iep_parse #(
        .LENGTH_BITS       (LENGTH_BITS),
        .MAX_LENGTH_DIGITS (MAX_LENGTH_DIGITS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .byte_value   (in_byte_reg),
        .last_byte    (in_last_reg),
        .message_type (msg_type_reg),
        .res_valid    (core_valid),
        .res          (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_type_reg  <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                msg_type_reg <= cfg_write_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            in_byte_reg <= byte_value;
            in_last_reg <= last_byte;
        end
        if (out_free && step)
            out_reg <= core_res;
    end

    assign result_valid  = out_valid_reg;
    assign result_kind   = out_reg.kind;
    assign data_type     = out_reg.data_type;
    assign data_byte     = out_reg.data_byte;
    assign byte_offset   = out_reg.byte_offset;
    assign record_length = out_reg.record_length;
    assign symbology     = out_reg.symbology;
    assign image_length  = out_reg.image_length;
    assign error_code    = out_reg.error_code;

`ifndef SYNTHESIS
    // An error beat always names its error.
    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_ERROR) |-> (error_code != ERR_NONE))
        else $error("error result without an error code");

    // Every other beat carries no error code.
    a_clean_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind != KIND_ERROR) |-> (error_code == ERR_NONE))
        else $error("non-error result with an error code");

    // A byte that produced a result shows up in the result register next cycle.
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step && core_valid |=> result_valid)
        else $error("parsed result lost");

    // The byte channel stalls only while a byte waits in the input register.
    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> in_valid_reg && out_valid_reg)
        else $error("byte channel stalled with room to spare");
`endif

endmodule

FILE: rtl/core/iep_parse.sv
// Parse state and per-byte next-state logic of the envelope parser.
// Depends on iep_pkg for the phase encoding, name table and result record.
module iep_parse
    import iep_pkg::*;
#(
    parameter int LENGTH_BITS       = 24,
    parameter int MAX_LENGTH_DIGITS = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    input  logic [7:0]  message_type,
    output logic        res_valid,
    output result_t     res
);

    localparam int PW = LENGTH_BITS + 4;

    phase_t                   phase_reg, phase_next;
    logic [31:0]              count_reg, count_next;
    logic [31:0]              decl_reg, decl_next;
    logic [3:0]               fpos_reg, fpos_next;
    logic [NUM_NAMES-1:0]     flags_reg, flags_next;
    logic [1:0]               ctype_reg, ctype_next;
    logic [LENGTH_BITS-1:0]   acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]   dpos_reg, dpos_next;
    logic [7:0]               symb_reg, symb_next;
    logic [31:0]              img_reg, img_next;
    logic                     elatch_reg, elatch_next;

    logic [PW-1:0]            acc_wide;
    logic [PW-1:0]            acc_prod;
    logic [31:0]              acc32;
    logic [31:0]              dpos32;
    logic [LENGTH_BITS-1:0]   dpos_inc;
    logic [NUM_NAMES-1:0]     flags_upd;
    logic [3:0]               err;
    logic                     restart;
    logic                     clear_rec;
    logic                     is_len;
    logic                     is_body;
    logic                     found;
    logic [1:0]               found_type;
    logic [31:0]              img_out;

    assign acc_wide = PW'(acc_reg);
    assign acc_prod = (acc_wide << 3) + (acc_wide << 1) + PW'(byte_value - CHAR_ZERO);
    assign acc32    = 32'(acc_reg);
    assign dpos32   = 32'(dpos_reg);
    assign dpos_inc = dpos_reg + 1'b1;

    assign is_len  = (phase_reg == PH_LEN0) || (phase_reg == PH_LEN1) ||
                     (phase_reg == PH_LEN2) || (phase_reg == PH_LEN3);
    assign is_body = !is_len && (phase_reg != PH_TYPE) &&
                     (phase_reg != PH_HDR0) && (phase_reg != PH_HDR1) &&
                     (phase_reg != PH_HDR2) && (phase_reg != PH_HDR3);

    // Name candidates: drop any whose character at this position differs.
    always_comb
    begin
        found      = 1'b0;
        found_type = TYPE_BARCODE;
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            flags_upd[i] = flags_reg[i] && (fpos_reg < NAME_LEN[i]) &&
                           (NAME_CHARS[i][fpos_reg[2:0]] == byte_value);
            if (flags_reg[i] && (NAME_LEN[i] == fpos_reg))
            begin
                found      = 1'b1;
                found_type = 2'(i);
            end
        end
    end

    // Image length with the bytes the record did not hold counted as zero.
    always_comb
    begin
        if (dpos32 <= 32'd2)
            img_out = '0;
        else if (dpos32 == 32'd3)
            img_out = {img_reg[7:0], 24'd0};
        else if (dpos32 == 32'd4)
            img_out = {img_reg[15:0], 16'd0};
        else if (dpos32 == 32'd5)
            img_out = {img_reg[23:0], 8'd0};
        else
            img_out = img_reg;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        decl_next   = decl_reg;
        fpos_next   = fpos_reg;
        flags_next  = flags_reg;
        ctype_next  = ctype_reg;
        acc_next    = acc_reg;
        dpos_next   = dpos_reg;
        symb_next   = symb_reg;
        img_next    = img_reg;
        elatch_next = elatch_reg;
        err         = ERR_NONE;
        restart     = 1'b0;
        clear_rec   = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        if (elatch_reg)
        begin
            restart = last_byte;
        end
        else
        begin
            // Length accounting comes first and wins over other errors.
            if (is_len)
            begin
                if (last_byte)
                    err = ERR_LENGTH;
            end
            else if ((count_reg >= decl_reg) ||
                     (last_byte && (count_reg + 32'd1 != decl_reg)))
            begin
                err = ERR_LENGTH;
            end
            else
            begin
                count_next = count_reg + 32'd1;
            end

            if ((err == ERR_NONE) && last_byte && is_body)
            begin
                if ((phase_reg == PH_REC) && (byte_value == CHAR_EOT))
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_COMPLETE;
                    restart   = 1'b1;
                end
                else
                begin
                    err = ERR_EOT;
                end
            end

            if ((err == ERR_NONE) && !restart)
            begin
                unique case (phase_reg)
                    PH_LEN0:
                    begin
                        decl_next  = {decl_reg[23:0], byte_value};
                        phase_next = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        decl_next  = {decl_reg[23:0], byte_value};
                        phase_next = PH_LEN2;
                    end
                    PH_LEN2:
                    begin
                        decl_next  = {decl_reg[23:0], byte_value};
                        phase_next = PH_LEN3;
                    end
                    PH_LEN3:
                    begin
                        decl_next  = {decl_reg[23:0], byte_value};
                        phase_next = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        if (byte_value != message_type) err = ERR_TYPE;
                        else phase_next = PH_HDR0;
                    end
                    PH_HDR0:
                    begin
                        if (byte_value != CHAR_LBRK) err = ERR_HEADER;
                        else phase_next = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        if (byte_value != CHAR_RPAR) err = ERR_HEADER;
                        else phase_next = PH_HDR2;
                    end
                    PH_HDR2:
                    begin
                        if (byte_value != CHAR_GT) err = ERR_HEADER;
                        else phase_next = PH_HDR3;
                    end
                    PH_HDR3:
                    begin
                        if (byte_value != CHAR_RS) err = ERR_HEADER;
                        else phase_next = PH_REC;
                    end
                    PH_REC:
                    begin
                        if (byte_value == CHAR_EOT) err = ERR_EOT;
                        else if (byte_value != CHAR_ZERO) err = ERR_FORMAT;
                        else phase_next = PH_FMT9;
                    end
                    PH_FMT9:
                    begin
                        if (byte_value != CHAR_NINE) err = ERR_FORMAT;
                        else phase_next = PH_GS1;
                    end
                    PH_GS1:
                    begin
                        if (byte_value != CHAR_GS) err = ERR_GS;
                        else phase_next = PH_NAME;
                    end
                    PH_NAME:
                    begin
                        if (byte_value == CHAR_GS)
                        begin
                            if (!found)
                            begin
                                err = ERR_NAME;
                            end
                            else
                            begin
                                ctype_next = found_type;
                                fpos_next  = '0;
                                phase_next = PH_GS2;
                            end
                        end
                        else
                        begin
                            flags_next = flags_upd;
                            if (fpos_reg != 4'd15)
                                fpos_next = fpos_reg + 4'd1;
                            if (flags_upd == '0)
                                err = ERR_NAME;
                        end
                    end
                    PH_GS2:
                    begin
                        if (byte_value != CHAR_GS) err = ERR_GS;
                        else phase_next = PH_DIGITS;
                    end
                    PH_DIGITS:
                    begin
                        if (byte_value == CHAR_GS)
                        begin
                            if ((fpos_reg == '0) ||
                                ((ctype_reg == TYPE_BARCODE) && (acc_reg == '0)))
                                err = ERR_NUMBER;
                            else if (acc_reg == '0)
                                phase_next = PH_RSEND;
                            else
                                phase_next = PH_DATA;
                        end
                        else if ((byte_value < CHAR_ZERO) || (byte_value > CHAR_NINE) ||
                                 (fpos_reg >= 4'(MAX_LENGTH_DIGITS)))
                        begin
                            err = ERR_NUMBER;
                        end
                        else
                        begin
                            acc_next  = acc_prod[LENGTH_BITS-1:0];
                            fpos_next = fpos_reg + 4'd1;
                            if (acc_prod[PW-1:LENGTH_BITS] != '0)
                                err = ERR_NUMBER;
                        end
                    end
                    PH_DATA:
                    begin
                        if (ctype_reg == TYPE_BARCODE)
                        begin
                            if (dpos_reg == '0)
                                symb_next = byte_value;
                        end
                        else if ((dpos32 >= 32'd2) && (dpos32 <= 32'd5))
                        begin
                            img_next = {img_reg[23:0], byte_value};
                        end
                        res_valid         = 1'b1;
                        res.kind          = KIND_PAYLOAD;
                        res.data_type     = ctype_reg;
                        res.data_byte     = byte_value;
                        res.byte_offset   = dpos32[23:0];
                        res.record_length = acc32[23:0];
                        dpos_next         = dpos_inc;
                        if (dpos_inc >= acc_reg)
                            phase_next = PH_RSEND;
                    end
                    PH_RSEND:
                    begin
                        if (byte_value != CHAR_RS)
                        begin
                            err = ERR_RS;
                        end
                        else
                        begin
                            res_valid         = 1'b1;
                            res.kind          = KIND_RECORD_END;
                            res.data_type     = ctype_reg;
                            res.record_length = acc32[23:0];
                            if (ctype_reg == TYPE_BARCODE)
                                res.symbology = symb_reg;
                            else
                                res.image_length = img_out;
                            clear_rec  = 1'b1;
                            phase_next = PH_REC;
                        end
                    end
                    default:
                    begin
                        err = ERR_EOT;
                    end
                endcase

                if ((err == ERR_NONE) && last_byte && !res_valid)
                    err = ERR_EOT;
            end

            if (err != ERR_NONE)
            begin
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = err;
                if (last_byte) restart = 1'b1;
                else elatch_next = 1'b1;
            end
        end

        if (clear_rec || restart)
        begin
            fpos_next  = '0;
            flags_next = '1;
            ctype_next = TYPE_BARCODE;
            acc_next   = '0;
            dpos_next  = '0;
            symb_next  = '0;
            img_next   = '0;
        end
        if (restart)
        begin
            phase_next  = PH_LEN0;
            count_next  = '0;
            decl_next   = '0;
            elatch_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN0;
            count_reg  <= '0;
            decl_reg   <= '0;
            fpos_reg   <= '0;
            flags_reg  <= '1;
            ctype_reg  <= TYPE_BARCODE;
            acc_reg    <= '0;
            dpos_reg   <= '0;
            symb_reg   <= '0;
            img_reg    <= '0;
            elatch_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            decl_reg   <= decl_next;
            fpos_reg   <= fpos_next;
            flags_reg  <= flags_next;
            ctype_reg  <= ctype_next;
            acc_reg    <= acc_next;
            dpos_reg   <= dpos_next;
            symb_reg   <= symb_next;
            img_reg    <= img_next;
            elatch_reg <= elatch_next;
        end
    end

endmodule

FILE: dv/tb_iso15434_envelope_parser.sv
// Self-checking testbench for iso15434_envelope_parser: byte stimulus, result checking
// and a byte-by-byte prediction of the envelope parse state.
// Depends on iep_pkg and on the RTL of iso15434_envelope_parser.
`timescale 1ns / 100ps

module tb_iso15434_envelope_parser;
    import iep_pkg::*;

    localparam int LEN_BITS    = 24;
    localparam int LEN_DIGITS  = 9;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 80;

    // The package only names the barcode type; the image types follow it.
    localparam logic [1:0] TYPE_BMP  = 2'd1;
    localparam logic [1:0] TYPE_JPEG = 2'd2;
    localparam logic [1:0] TYPE_TIFF = 2'd3;

    localparam logic [31:0] MAX_RECORD_LEN = (32'd1 << LEN_BITS) - 32'd1;

    // One byte beat waiting to be offered on the byte channel.
    typedef struct {
        logic [7:0] value;
        logic       last;
    } byte_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [7:0]  cfg_write_data = 8'h00;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  byte_value = 8'h00;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [1:0]  data_type;
    logic [7:0]  data_byte;
    logic [23:0] byte_offset;
    logic [23:0] record_length;
    logic [7:0]  symbology;
    logic [31:0] image_length;
    logic [3:0]  error_code;

    iso15434_envelope_parser #(
        .LENGTH_BITS       (LEN_BITS),
        .MAX_LENGTH_DIGITS (LEN_DIGITS)
    ) dut (.*);

    always #2 clk = ~clk;

    // Shared between the stimulus builder, the driver and the monitor.
    byte_beat_t  byte_feed[$];        // bytes not yet offered to the block
    result_t     awaited_results[$];  // predicted result beats, oldest first
    logic [7:0]  pkt_body[$];         // packet under construction, after the length header
    logic [7:0]  cur_msg;             // message type the stimulus is built for
    int          idle_odds = 0;       // one idle burst per this many beats, 0 for none
    int          fed_count = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    // ------------------------------------------------------------------
    // Envelope tracker: our own copy of the parse state. It is advanced once
    // for every byte beat the block accepts and queues the result beat, if
    // any, that the byte must produce.
    // ------------------------------------------------------------------
    phase_t      trk_phase;
    logic [31:0] trk_count;   // body bytes counted against the length header
    logic [31:0] trk_len;     // length from the header
    logic [3:0]  trk_fpos;    // name characters or length digits seen
    logic [3:0]  trk_live;    // type names that can still match
    logic [1:0]  trk_type;
    logic [31:0] trk_acc;     // decimal record length being accumulated
    logic [31:0] trk_dpos;    // offset of the next data byte
    logic [7:0]  trk_symb;
    logic [31:0] trk_img;
    logic        trk_dead;    // an error was reported, skip to the last byte
    logic [7:0]  trk_msg;     // mirror of the message type register

    task automatic trk_clear_record();
        trk_fpos = '0;
        trk_live = 4'hF;
        trk_type = TYPE_BARCODE;
        trk_acc  = '0;
        trk_dpos = '0;
        trk_symb = '0;
        trk_img  = '0;
    endtask

    task automatic trk_restart();
        trk_phase = PH_LEN0;
        trk_count = '0;
        trk_len   = '0;
        trk_dead  = 1'b0;
        trk_clear_record();
    endtask

    task automatic env_parse_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic [3:0]  err;
        logic        found;
        logic [31:0] img;
        int          i;
        r   = '0;
        err = ERR_NONE;

        // After an error everything up to and including the last byte is
        // swallowed silently.
        if (trk_dead)
        begin
            if (last)
                trk_restart();
            return;
        end

        // Length accounting comes first and beats every other error.
        if (trk_phase < PH_TYPE)
        begin
            if (last)
                err = ERR_LENGTH;
        end
        else if (trk_count >= trk_len ||
                 (last && (33'(trk_count) + 33'd1) != 33'(trk_len)))
        begin
            err = ERR_LENGTH;
        end
        else
        begin
            trk_count++;
        end

        // A last byte past the header must be EOT at a record boundary.
        if (err == ERR_NONE && last && trk_phase >= PH_REC)
        begin
            if (trk_phase == PH_REC && b == CHAR_EOT)
            begin
                r.kind = KIND_COMPLETE;
                awaited_results.push_back(r);
                trk_restart();
                return;
            end
            err = ERR_EOT;
        end

        if (err == ERR_NONE)
        begin
            case (trk_phase)
                PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
                begin
                    trk_len   = {trk_len[23:0], b};
                    trk_phase = phase_t'(trk_phase << 1);
                end
                PH_TYPE:
                    if (b != trk_msg) err = ERR_TYPE; else trk_phase = PH_HDR0;
                PH_HDR0:
                    if (b != CHAR_LBRK) err = ERR_HEADER; else trk_phase = PH_HDR1;
                PH_HDR1:
                    if (b != CHAR_RPAR) err = ERR_HEADER; else trk_phase = PH_HDR2;
                PH_HDR2:
                    if (b != CHAR_GT) err = ERR_HEADER; else trk_phase = PH_HDR3;
                PH_HDR3:
                    if (b != CHAR_RS) err = ERR_HEADER; else trk_phase = PH_REC;
                PH_REC:
                begin
                    if (b == CHAR_EOT)
                        err = ERR_EOT;
                    else if (b != CHAR_ZERO)
                        err = ERR_FORMAT;
                    else
                        trk_phase = PH_FMT9;
                end
                PH_FMT9:
                    if (b != CHAR_NINE) err = ERR_FORMAT; else trk_phase = PH_GS1;
                PH_GS1:
                    if (b != CHAR_GS) err = ERR_GS; else trk_phase = PH_NAME;
                PH_NAME:
                begin
                    if (b == CHAR_GS)
                    begin
                        // The name ends here: a live candidate must have exactly this length.
                        found = 1'b0;
                        for (i = 0; i < NUM_NAMES; i++)
                        begin
                            if (trk_live[i] && NAME_LEN[i] == trk_fpos)
                            begin
                                trk_type = 2'(i);
                                found    = 1'b1;
                            end
                        end
                        if (!found)
                        begin
                            err = ERR_NAME;
                        end
                        else
                        begin
                            trk_fpos  = '0;
                            trk_phase = PH_GS2;
                        end
                    end
                    else
                    begin
                        for (i = 0; i < NUM_NAMES; i++)
                        begin
                            if (trk_fpos >= NAME_LEN[i] || NAME_CHARS[i][trk_fpos[2:0]] != b)
                                trk_live[i] = 1'b0;
                        end
                        if (trk_fpos < 4'd15)
                            trk_fpos++;
                        if (trk_live == 4'h0)
                            err = ERR_NAME;
                    end
                end
                PH_GS2:
                    if (b != CHAR_GS) err = ERR_GS; else trk_phase = PH_DIGITS;
                PH_DIGITS:
                begin
                    if (b == CHAR_GS)
                    begin
                        // No digits, or a barcode without data, is a bad number.
                        if (trk_fpos == 0 || (trk_type == TYPE_BARCODE && trk_acc == 0))
                            err = ERR_NUMBER;
                        else
                            trk_phase = (trk_acc == 0) ? PH_RSEND : PH_DATA;
                    end
                    else if (b < CHAR_ZERO || b > CHAR_NINE || trk_fpos >= LEN_DIGITS)
                    begin
                        err = ERR_NUMBER;
                    end
                    else
                    begin
                        trk_acc = trk_acc * 32'd10 + 32'(b - CHAR_ZERO);
                        trk_fpos++;
                        if (trk_acc > MAX_RECORD_LEN)
                            err = ERR_NUMBER;
                    end
                end
                PH_DATA:
                begin
                    // Barcodes keep their first byte; images keep data bytes 2 to 5.
                    if (trk_type == TYPE_BARCODE)
                    begin
                        if (trk_dpos == 0)
                            trk_symb = b;
                    end
                    else if (trk_dpos >= 2 && trk_dpos <= 5)
                    begin
                        trk_img = {trk_img[23:0], b};
                    end
                    r.kind          = KIND_PAYLOAD;
                    r.data_type     = trk_type;
                    r.data_byte     = b;
                    r.byte_offset   = trk_dpos[23:0];
                    r.record_length = trk_acc[23:0];
                    trk_dpos++;
                    if (trk_dpos >= trk_acc)
                        trk_phase = PH_RSEND;
                    awaited_results.push_back(r);
                    return;
                end
                PH_RSEND:
                begin
                    if (b != CHAR_RS)
                    begin
                        err = ERR_RS;
                    end
                    else
                    begin
                        r.kind          = KIND_RECORD_END;
                        r.data_type     = trk_type;
                        r.record_length = trk_acc[23:0];
                        if (trk_type == TYPE_BARCODE)
                        begin
                            r.symbology = trk_symb;
                        end
                        else
                        begin
                            // Image bytes the record never held read as zero.
                            img = trk_img;
                            if (trk_dpos < 2)
                                img = '0;
                            else if (trk_dpos < 6)
                                img = img << (8 * (6 - trk_dpos));
                            r.image_length = img;
                        end
                        awaited_results.push_back(r);
                        trk_clear_record();
                        trk_phase = PH_REC;
                        return;
                    end
                end
                default:
                    err = ERR_EOT;
            endcase
        end

        if (err == ERR_NONE && last)
            err = ERR_EOT;

        if (err != ERR_NONE)
        begin
            r.kind       = KIND_ERROR;
            r.error_code = err;
            awaited_results.push_back(r);
            if (last)
                trk_restart();
            else
                trk_dead = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Packet building. A packet is assembled in pkt_body (message type
    // onward), then shipped with a length header and the last flag on its
    // final byte.
    // ------------------------------------------------------------------
    task automatic feed_byte(input logic [7:0] v, input logic last);
        byte_beat_t nb;
        nb.value = v;
        nb.last  = last;
        byte_feed.push_back(nb);
        fed_count++;
    endtask

    task automatic ship(input logic [31:0] len_field);
        int k;
        feed_byte(len_field[31:24], 1'b0);
        feed_byte(len_field[23:16], 1'b0);
        feed_byte(len_field[15:8], 1'b0);
        feed_byte(len_field[7:0], 1'b0);
        for (k = 0; k < pkt_body.size(); k++)
            feed_byte(pkt_body[k], k == pkt_body.size() - 1);
    endtask

    task automatic begin_packet(input logic [7:0] mt);
        pkt_body.delete();
        pkt_body.push_back(mt);
        pkt_body.push_back(CHAR_LBRK);
        pkt_body.push_back(CHAR_RPAR);
        pkt_body.push_back(CHAR_GT);
        pkt_body.push_back(CHAR_RS);
    endtask

    task automatic finish_packet();
        pkt_body.push_back(CHAR_EOT);
        ship(pkt_body.size());
    endtask

    task automatic put_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            pkt_body.push_back(s[k]);
    endtask

    task automatic put_data(input int n);
        repeat (n) pkt_body.push_back(8'($urandom));
    endtask

    // Record header up to the data: format, type name, empty compression
    // field and the decimal length.
    task automatic put_head(input string name, input string digits);
        put_str("09");
        pkt_body.push_back(CHAR_GS);
        put_str(name);
        pkt_body.push_back(CHAR_GS);
        pkt_body.push_back(CHAR_GS);
        put_str(digits);
        pkt_body.push_back(CHAR_GS);
    endtask

    function automatic string type_name(input logic [1:0] t);
        case (t)
            TYPE_BARCODE: return "BarCode";
            TYPE_BMP:     return "BMP";
            TYPE_JPEG:    return "JPEG";
            default:      return "TIFF";
        endcase
    endfunction

    task automatic put_record(input logic [1:0] rtype, input int n);
        string digits;
        digits = $sformatf("%0d", n);
        if ($urandom_range(0, 5) == 0)
            digits = {"0", digits};
        put_head(type_name(rtype), digits);
        put_data(n);
        pkt_body.push_back(CHAR_RS);
    endtask

    // Mostly well-formed envelopes with random records; the rest have a byte
    // corrupted, are cut short, carry a wrong length, or are plain noise.
    task automatic add_random_packet();
        int          pick, nrec, n, k, pos;
        logic [1:0]  rtype;
        logic [31:0] len_field;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++)
                feed_byte(8'($urandom), k == n - 1 || $urandom_range(0, 7) == 0);
            return;
        end
        begin_packet(cur_msg);
        nrec = $urandom_range(0, 3);
        repeat (nrec)
        begin
            rtype = 2'($urandom_range(0, 3));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            if (rtype == TYPE_BARCODE && n == 0)
                n = 1;
            put_record(rtype, n);
        end
        pkt_body.push_back(CHAR_EOT);
        len_field = pkt_body.size();
        case (pick)
            1, 2:
            begin
                pos = $urandom_range(0, pkt_body.size() - 1);
                pkt_body[pos] = 8'($urandom);
            end
            3, 4:
            begin
                n = $urandom_range(1, pkt_body.size());
                while (pkt_body.size() > n)
                    void'(pkt_body.pop_back());
                len_field = pkt_body.size();
            end
            5:
            begin
                if ($urandom_range(0, 1) == 1)
                    len_field++;
                else
                    len_field--;
            end
            default:
            begin
            end
        endcase
        ship(len_field);
    endtask

    task automatic add_random_bytes(input int amount);
        int start;
        start = fed_count;
        while (fed_count - start < amount)
            add_random_packet();
    endtask

    // ------------------------------------------------------------------
    // Configuration and phase boundaries.
    // ------------------------------------------------------------------
    task set_msg_type(input logic [7:0] v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        trk_msg = v;
        cur_msg = v;
    endtask

    // Wait until every byte is taken and every predicted beat has arrived,
    // then allow for a byte that produces no result still being in the
    // two-stage pipeline.
    task settle();
        while (byte_feed.size() != 0 || byte_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers byte beats from byte_feed. A beat, once offered, holds
    // until it is accepted; idle bursts fall between beats.
    // ------------------------------------------------------------------
    int         send_gap = 0;
    byte_beat_t send_next;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_value <= 8'h00;
            last_byte  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                env_parse_byte(byte_value, last_byte);
            if (!byte_valid || !byte_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end
                else if (byte_feed.size() == 0)
                begin
                    byte_valid <= 1'b0;
                end
                else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                begin
                    send_gap = $urandom_range(0, 8);
                    byte_valid <= 1'b0;
                end
                else
                begin
                    send_next = byte_feed.pop_front();
                    byte_valid <= 1'b1;
                    byte_value <= send_next.value;
                    last_byte  <= send_next.last;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result beat against the oldest
    // prediction and drives the result stall. Now and then it holds off for
    // a long stretch so that both pipeline registers fill and the byte
    // channel backs up.
    // ------------------------------------------------------------------
    int      sink_gap = 0;
    int      hold_left = 0;
    int      seen_results = 0;
    int      next_hold_at = 150;
    result_t want;

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            sink_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                seen_results++;
                if (awaited_results.size() == 0)
                begin
                    $error("result beat of kind %0d with no prediction waiting", result_kind);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", want.kind, result_kind);
                    check_field("data_type", want.data_type, data_type);
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("byte_offset", want.byte_offset, byte_offset);
                    check_field("record_length", want.record_length, record_length);
                    check_field("symbology", want.symbology, symbology);
                    check_field("image_length", want.image_length, image_length);
                    check_field("error_code", want.error_code, error_code);
                end
            end
            if (hold_left == 0 && idle_odds != 0 && seen_results >= next_hold_at)
            begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                result_stall <= 1'b1;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                sink_gap = $urandom_range(0, 8);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Run limit, far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence: directed envelopes, then four random phases with
    // different message types and idling, the last without idling.
    // ------------------------------------------------------------------
    initial
    begin
        string      bad_names [7];
        string      num_digits [6];
        logic [1:0] num_types [6];

        bad_names  = '{"BarCodx", "BM", "BarCodeX", "", "bmp", "JPE", "TIFFF"};
        num_digits = '{"1a", "1234567890", "16777216", "", "0", "000"};
        num_types  = '{TYPE_BMP, TYPE_JPEG, TYPE_TIFF, TYPE_BMP, TYPE_BARCODE, TYPE_BARCODE};

        trk_msg = 8'h00;
        trk_restart();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_odds = 6;
        set_msg_type(8'h00);

        // Empty envelope: header straight into the trailer.
        begin_packet(cur_msg);
        finish_packet();

        // Every record type, data extremes, a nine-digit length with leading
        // zeros, an image of zero length, a short image, and data bytes that
        // look like control characters.
        begin_packet(cur_msg);
        put_head("BarCode", "1");
        pkt_body.push_back(8'hFF);
        pkt_body.push_back(CHAR_RS);
        put_head("BarCode", "2");
        pkt_body.push_back(8'h00);
        pkt_body.push_back(8'h7F);
        pkt_body.push_back(CHAR_RS);
        put_head("BMP", "6");
        pkt_body.push_back(8'h00);
        pkt_body.push_back(8'h00);
        repeat (4) pkt_body.push_back(8'hFF);
        pkt_body.push_back(CHAR_RS);
        put_head("JPEG", "0");
        pkt_body.push_back(CHAR_RS);
        put_record(TYPE_JPEG, 8);
        put_head("TIFF", "3");
        put_data(3);
        pkt_body.push_back(CHAR_RS);
        put_head("BarCode", "000000003");
        pkt_body.push_back(CHAR_GS);
        pkt_body.push_back(CHAR_RS);
        pkt_body.push_back(CHAR_EOT);
        pkt_body.push_back(CHAR_RS);
        finish_packet();

        // Length header disagreeing with the body: one short, one long,
        // zero, all ones, and a last byte inside the header itself.
        begin_packet(cur_msg);
        put_record(TYPE_BMP, 2);
        pkt_body.push_back(CHAR_EOT);
        ship(pkt_body.size() - 1);
        begin_packet(cur_msg);
        put_record(TYPE_JPEG, 2);
        pkt_body.push_back(CHAR_EOT);
        ship(pkt_body.size() + 1);
        begin_packet(cur_msg);
        pkt_body.push_back(CHAR_EOT);
        ship(32'h0000_0000);
        ship(32'hFFFF_FFFF);
        feed_byte(8'h00, 1'b0);
        feed_byte(8'h06, 1'b1);

        // Wrong message type, then a broken header marker.
        begin_packet(~cur_msg);
        finish_packet();
        begin_packet(cur_msg);
        pkt_body[1] = 8'h28;
        finish_packet();

        // Packet ending inside the header, with good and with bad content.
        begin_packet(cur_msg);
        void'(pkt_body.pop_back());
        void'(pkt_body.pop_back());
        ship(pkt_body.size());
        pkt_body[2] = 8'h3C;
        ship(pkt_body.size());

        // Bad format digits.
        begin_packet(cur_msg);
        put_str("19");
        finish_packet();
        begin_packet(cur_msg);
        put_str("08");
        finish_packet();

        // EOT early at a record boundary, and a last byte that is not EOT.
        begin_packet(cur_msg);
        pkt_body.push_back(CHAR_EOT);
        finish_packet();
        begin_packet(cur_msg);
        put_record(TYPE_BARCODE, 1);
        pkt_body.push_back(8'h41);
        ship(pkt_body.size());

        // Missing separator after the format, and a non-empty compression field.
        begin_packet(cur_msg);
        put_str("09B");
        finish_packet();
        begin_packet(cur_msg);
        put_str("09");
        pkt_body.push_back(CHAR_GS);
        put_str("TIFF");
        pkt_body.push_back(CHAR_GS);
        put_str("Z");
        finish_packet();

        // Type names that go wrong mid-way, end too early or run too long.
        foreach (bad_names[k])
        begin
            begin_packet(cur_msg);
            put_head(bad_names[k], "1");
            put_data(1);
            pkt_body.push_back(CHAR_RS);
            finish_packet();
        end

        // Bad lengths: non-digit, too many digits, too large, empty, and a
        // zero-length barcode.
        foreach (num_digits[k])
        begin
            begin_packet(cur_msg);
            put_head(type_name(num_types[k]), num_digits[k]);
            put_data(2);
            pkt_body.push_back(CHAR_RS);
            finish_packet();
        end

        // Data not closed by RS.
        begin_packet(cur_msg);
        put_head("JPEG", "2");
        put_data(2);
        pkt_body.push_back(CHAR_GS);
        finish_packet();

        // Largest record length; the packet ends inside the data.
        begin_packet(cur_msg);
        put_head("BarCode", "16777215");
        put_data(3);
        ship(pkt_body.size());

        // Packet ending inside a type name.
        begin_packet(cur_msg);
        put_str("09");
        pkt_body.push_back(CHAR_GS);
        put_str("TI");
        ship(pkt_body.size());

        add_random_bytes(240);
        settle();

        idle_odds = 10;
        set_msg_type(8'hFF);
        add_random_bytes(250);
        settle();

        idle_odds = 4;
        set_msg_type(8'($urandom));
        add_random_bytes(250);
        settle();

        // Closing stretch at full rate on both channels.
        idle_odds = 0;
        set_msg_type(8'($urandom));
        add_random_bytes(250);
        settle();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/iep_pkg.sv
rtl/core/iep_parse.sv
rtl/core/iso15434_envelope_parser.sv
dv/tb_iso15434_envelope_parser.sv
